[hw/rtl/urpd_pkg.sv]
// Package for the ultrasonic range presence detector.
// Holds register defaults, phase and event codes and the records passed between the modules.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package urpd_pkg;

  localparam int unsigned DIST_W    = 13;
  localparam int unsigned TMO_W     = 16;
  localparam int unsigned TRIG_W    = 8;
  localparam int unsigned PAUSE_W   = 20;
  localparam int unsigned CFG_DW    = 20;
  localparam int unsigned CFG_IW    = 3;
  localparam int unsigned SAMPLES   = 3;

  localparam logic [DIST_W-1:0]  DETECT_BELOW_RST = 13'd100;
  localparam logic [DIST_W-1:0]  CLEAR_AT_RST     = 13'd120;
  localparam logic [TMO_W-1:0]   ECHO_TMO_RST     = 16'd30000;
  localparam logic [TRIG_W-1:0]  TRIGGER_RST      = 8'd10;
  localparam logic [PAUSE_W-1:0] PAUSE_RST        = 20'd200000;

  // Distance is floor(width * 5 / 29), done as a multiply by a rounded-up reciprocal.
  localparam int unsigned        SCALED_W  = TMO_W + 3;
  localparam int unsigned        RECIP_W   = 20;
  localparam int unsigned        RECIP_SH  = 24;
  localparam int unsigned        PROD_W    = SCALED_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_29  = 20'd578525;
  localparam logic [DIST_W-1:0]  DIST_MAX  = 13'd8191;

  typedef enum logic [1:0] {
    PH_PAUSE,
    PH_TRIG,
    PH_RISE,
    PH_FALL
  } phase_t;

  typedef enum logic [1:0] {
    EV_DIST,
    EV_DETECT,
    EV_CLEAR,
    EV_FAIL
  } event_t;

  typedef enum logic [CFG_IW-1:0] {
    CFG_DETECT_BELOW,
    CFG_CLEAR_AT,
    CFG_ECHO_TIMEOUT,
    CFG_TRIGGER_TICKS,
    CFG_PAUSE_TICKS
  } cfg_idx_t;

  typedef struct packed {
    logic [DIST_W-1:0]  detect_below;
    logic [DIST_W-1:0]  clear_at;
    logic [TMO_W-1:0]   echo_timeout;
    logic [TRIG_W-1:0]  trigger_ticks;
    logic [PAUSE_W-1:0] pause_ticks;
  } cfg_t;

  // Outcome of one tick as worked out by the front part.
  typedef struct packed {
    logic             trig;
    logic             done;
    logic             failed;
    logic [1:0]       idx;
    logic [TMO_W-1:0] width;
  } tick_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage
`default_nettype wire

[hw/rtl/urpd_if.sv]
// Valid/ready channel interfaces for the ultrasonic range presence detector.
// Depends on urpd_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none
interface urpd_in_if;
  logic valid;
  logic ready;
  logic echo_level;

  modport source (output valid, output echo_level, input ready);
  modport sink (input valid, input echo_level, output ready);
endinterface

interface urpd_out_if;
  logic                             valid;
  logic                             ready;
  logic                             trigger_level;
  logic                             report_valid;
  logic [1:0]                       event_code;
  logic [urpd_pkg::DIST_W-1:0]      distance_tenths;
  logic                             present;

  modport source (output valid, output trigger_level, output report_valid,
                  output event_code, output distance_tenths, output present,
                  input ready);
  modport sink (input valid, input trigger_level, input report_valid,
                input event_code, input distance_tenths, input present,
                output ready);
endinterface
`default_nettype wire

[hw/rtl/urpd_front.sv]
// Front part: accepts echo ticks and runs the trigger, echo and pause sequencing.
// Pushes one tick record per transfer into the queue. Depends on urpd_pkg and urpd_if.
`timescale 1ns / 1ps
`default_nettype none
module urpd_front (
  input  wire                 clk,
  input  wire                 rst_n,
  input  urpd_pkg::cfg_t      cfg,
  urpd_in_if.sink             in_ch,
  input  urpd_pkg::q_stat_t   q_stat,
  output logic                q_push,
  output urpd_pkg::tick_rec_t q_data
);

  urpd_pkg::phase_t                  phase_r, phase_nxt;
  logic [urpd_pkg::PAUSE_W-1:0]      pc_r, pc_nxt;
  logic [urpd_pkg::TMO_W-1:0]        st_r, st_nxt;
  logic [urpd_pkg::TMO_W-1:0]        ew_r, ew_nxt;
  logic [1:0]                        si_r, si_nxt;
  logic                              trig, done, failed;

  assign in_ch.ready = !q_stat.full;
  assign q_push      = in_ch.valid && !q_stat.full;

  always_comb begin
    phase_nxt = phase_r;
    pc_nxt    = pc_r;
    st_nxt    = st_r;
    ew_nxt    = ew_r;
    si_nxt    = si_r;
    trig      = 1'b0;
    done      = 1'b0;
    failed    = 1'b0;

    if (phase_nxt == urpd_pkg::PH_PAUSE && pc_nxt >= cfg.pause_ticks) begin
      phase_nxt = urpd_pkg::PH_TRIG;
      pc_nxt    = '0;
    end

    case (phase_nxt)
      urpd_pkg::PH_PAUSE: begin
        pc_nxt = pc_nxt + 20'd1;
      end
      urpd_pkg::PH_TRIG: begin
        trig   = 1'b1;
        pc_nxt = pc_nxt + 20'd1;
        if (pc_nxt >= {12'd0, cfg.trigger_ticks}) begin
          phase_nxt = urpd_pkg::PH_RISE;
          pc_nxt    = '0;
          st_nxt    = '0;
          ew_nxt    = '0;
        end
      end
      default: begin
        if (st_r >= cfg.echo_timeout) begin
          done   = 1'b1;
          failed = 1'b1;
        end else begin
          st_nxt = st_r + 16'd1;
          if (in_ch.echo_level) begin
            ew_nxt    = ew_r + 16'd1;
            phase_nxt = urpd_pkg::PH_FALL;
          end else if (phase_r == urpd_pkg::PH_FALL) begin
            done = 1'b1;
          end
        end
      end
    endcase

    if (done) begin
      st_nxt = '0;
      ew_nxt = '0;
      pc_nxt = '0;
      if (si_r != 2'd2) begin
        si_nxt    = si_r + 2'd1;
        phase_nxt = urpd_pkg::PH_TRIG;
      end else begin
        si_nxt    = '0;
        phase_nxt = urpd_pkg::PH_PAUSE;
      end
    end
  end

  assign q_data = '{trig: trig, done: done, failed: failed, idx: si_r, width: ew_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= urpd_pkg::PH_PAUSE;
      pc_r    <= '0;
      st_r    <= '0;
      ew_r    <= '0;
      si_r    <= '0;
    end else if (q_push) begin
      phase_r <= phase_nxt;
      pc_r    <= pc_nxt;
      st_r    <= st_nxt;
      ew_r    <= ew_nxt;
      si_r    <= si_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/urpd_queue.sv]
// Two-entry queue of tick records between the front and the back part.
// Depends on urpd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module urpd_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  logic                push,
  input  urpd_pkg::tick_rec_t wr_data,
  input  logic                pop,
  output urpd_pkg::tick_rec_t rd_data,
  output urpd_pkg::q_stat_t   stat
);

  urpd_pkg::tick_rec_t mem_r [2];
  logic                wr_ptr_r, wr_ptr_nxt;
  logic                rd_ptr_r, rd_ptr_nxt;
  logic [1:0]          cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == 2'd2);
  assign stat.empty = (cnt_r == 2'd0);
  assign rd_data    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push;
    rd_ptr_nxt = rd_ptr_r ^ pop;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/urpd_back.sv]
// Back part: converts echo widths to distance, takes the median of a round,
// applies hysteresis and holds the output register. Depends on urpd_pkg and urpd_if.
`timescale 1ns / 1ps
`default_nettype none
module urpd_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  urpd_pkg::cfg_t      cfg,
  input  urpd_pkg::q_stat_t   q_stat,
  input  urpd_pkg::tick_rec_t q_data,
  output logic                q_pop,
  urpd_out_if.source          out_ch
);

  logic                                s1_v_r;
  urpd_pkg::tick_rec_t                 s1_rec_r;
  logic [urpd_pkg::PROD_W-1:0]         s1_prod_r, prod_nxt;
  logic [urpd_pkg::SCALED_W-1:0]       scaled;

  logic                                out_v_r;
  logic                                out_trig_r, out_rep_r;
  urpd_pkg::event_t                    out_code_r, code_nxt;
  logic [urpd_pkg::DIST_W-1:0]         out_dist_r, dist_nxt;
  logic                                rep_nxt;

  logic [urpd_pkg::DIST_W-1:0]         store_r [2];
  logic                                any_failed_r, any_failed_nxt;
  logic                                detected_r, detected_nxt;

  logic [urpd_pkg::PROD_W-urpd_pkg::RECIP_SH-1:0] quot;
  logic [urpd_pkg::DIST_W-1:0]         sample, lo, hi, mid, med;
  logic                                s2_load;

  assign s2_load = s1_v_r && (!out_v_r || out_ch.ready);
  assign q_pop   = !q_stat.empty && (!s1_v_r || s2_load);

  assign scaled   = {1'b0, q_data.width, 2'b00} + {3'b000, q_data.width};
  assign prod_nxt = {{urpd_pkg::RECIP_W{1'b0}}, scaled} *
                    {{urpd_pkg::SCALED_W{1'b0}}, urpd_pkg::RECIP_29};

  always_comb begin
    quot = s1_prod_r[urpd_pkg::PROD_W-1:urpd_pkg::RECIP_SH];
    if (s1_rec_r.failed) begin
      sample = '0;
    end else if (quot > {{(urpd_pkg::PROD_W-urpd_pkg::RECIP_SH-urpd_pkg::DIST_W){1'b0}},
                         urpd_pkg::DIST_MAX}) begin
      sample = urpd_pkg::DIST_MAX;
    end else begin
      sample = quot[urpd_pkg::DIST_W-1:0];
    end

    lo  = (store_r[0] < store_r[1]) ? store_r[0] : store_r[1];
    hi  = (store_r[0] < store_r[1]) ? store_r[1] : store_r[0];
    mid = (hi < sample) ? hi : sample;
    med = (lo > mid) ? lo : mid;

    rep_nxt        = 1'b0;
    code_nxt       = urpd_pkg::EV_DIST;
    dist_nxt       = '0;
    any_failed_nxt = any_failed_r;
    detected_nxt   = detected_r;

    if (s1_rec_r.done) begin
      if (s1_rec_r.idx != 2'd2) begin
        any_failed_nxt = any_failed_r | s1_rec_r.failed;
      end else begin
        rep_nxt        = 1'b1;
        any_failed_nxt = 1'b0;
        if (any_failed_r || s1_rec_r.failed) begin
          code_nxt = urpd_pkg::EV_FAIL;
        end else begin
          dist_nxt = med;
          if (med < cfg.detect_below && !detected_r) begin
            detected_nxt = 1'b1;
            code_nxt     = urpd_pkg::EV_DETECT;
          end else if (med >= cfg.clear_at && detected_r) begin
            detected_nxt = 1'b0;
            code_nxt     = urpd_pkg::EV_CLEAR;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_rec_r  <= q_data;
      s1_prod_r <= prod_nxt;
    end
    if (s2_load) begin
      out_trig_r <= s1_rec_r.trig;
      out_rep_r  <= rep_nxt;
      out_code_r <= code_nxt;
      out_dist_r <= dist_nxt;
      if (s1_rec_r.done && s1_rec_r.idx != 2'd2) begin
        store_r[s1_rec_r.idx[0]] <= sample;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      out_v_r      <= 1'b0;
      any_failed_r <= 1'b0;
      detected_r   <= 1'b0;
    end else begin
      if (q_pop) begin
        s1_v_r <= 1'b1;
      end else if (s2_load) begin
        s1_v_r <= 1'b0;
      end
      if (s2_load) begin
        out_v_r      <= 1'b1;
        any_failed_r <= any_failed_nxt;
        detected_r   <= detected_nxt;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.trigger_level   = out_trig_r;
  assign out_ch.report_valid    = out_rep_r;
  assign out_ch.event_code      = out_code_r;
  assign out_ch.distance_tenths = out_dist_r;
  assign out_ch.present         = detected_r;

  a_idle_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_rep_r |-> out_code_r == urpd_pkg::EV_DIST && out_dist_r == '0)
    else $error("idle result carries an event or a distance");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_code_r == urpd_pkg::EV_FAIL |-> out_dist_r == '0)
    else $error("failure report carries a distance");

  a_detect_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_code_r == urpd_pkg::EV_DETECT |-> detected_r)
    else $error("detect report without presence set");

  a_clear_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_code_r == urpd_pkg::EV_CLEAR |-> !detected_r)
    else $error("clear report with presence still set");

  a_flag_change: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && detected_r != $past(detected_r) |-> $past(s2_load) && out_rep_r)
    else $error("presence changed outside a round report");

endmodule
`default_nettype wire

[hw/rtl/ultrasonic_range_presence_detector.sv]
// Ultrasonic range presence detector, top level.
// Holds the configuration registers and joins the front part, the queue and the back part.
// Depends on urpd_pkg, urpd_if, urpd_front, urpd_queue and urpd_back.
//
// Each transfer on in_ch is one microsecond tick with the sampled echo level, and each
// one yields exactly one transfer on out_ch with the trigger level to drive for that tick.
// Every three echo measurements a report is flagged with report_valid, carrying the
// median distance in tenths of a centimetre, a detect, clear or failure event, and the
// presence flag.
// One tick is taken per cycle while the queue has room. A result passes from the
// front part into the queue, then the width multiplier stage and the output register.
// Configuration is written through cfg_we, cfg_index and cfg_data, one register per cycle;
// the user must write it only while no tick is in flight; the block does not enforce this.
// Synchronous reset restores the register defaults, starts in the pause before the first
// trigger, clears presence and empties the queue and the pipeline.
// When out_ch stalls, the result waits in the output register, the pipeline and the
// two-entry queue fill, and in_ch.ready falls until the receiver takes results again.
`timescale 1ns / 1ps
`default_nettype none
module ultrasonic_range_presence_detector (
  input  wire                          clk,
  input  wire                          rst_n,
  urpd_in_if.sink                      in_ch,
  urpd_out_if.source                   out_ch,
  input  wire                          cfg_we,
  input  wire [urpd_pkg::CFG_IW-1:0]   cfg_index,
  input  wire [urpd_pkg::CFG_DW-1:0]   cfg_data
);

  urpd_pkg::cfg_t      cfg_r, cfg_nxt;
  urpd_pkg::q_stat_t   q_stat;
  urpd_pkg::tick_rec_t q_wr, q_rd;
  logic                q_push, q_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        urpd_pkg::CFG_DETECT_BELOW:  cfg_nxt.detect_below  = cfg_data[urpd_pkg::DIST_W-1:0];
        urpd_pkg::CFG_CLEAR_AT:      cfg_nxt.clear_at      = cfg_data[urpd_pkg::DIST_W-1:0];
        urpd_pkg::CFG_ECHO_TIMEOUT:  cfg_nxt.echo_timeout  = cfg_data[urpd_pkg::TMO_W-1:0];
        urpd_pkg::CFG_TRIGGER_TICKS: cfg_nxt.trigger_ticks = cfg_data[urpd_pkg::TRIG_W-1:0];
        urpd_pkg::CFG_PAUSE_TICKS:   cfg_nxt.pause_ticks   = cfg_data[urpd_pkg::PAUSE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.detect_below  <= urpd_pkg::DETECT_BELOW_RST;
      cfg_r.clear_at      <= urpd_pkg::CLEAR_AT_RST;
      cfg_r.echo_timeout  <= urpd_pkg::ECHO_TMO_RST;
      cfg_r.trigger_ticks <= urpd_pkg::TRIGGER_RST;
      cfg_r.pause_ticks   <= urpd_pkg::PAUSE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  urpd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_data (q_wr)
  );

  urpd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr),
    .pop     (q_pop),
    .rd_data (q_rd),
    .stat    (q_stat)
  );

  urpd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .q_stat (q_stat),
    .q_data (q_rd),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire
